// File: rtl/skel_pkg.sv
// Shared constants and types for the skeleton end/junction point detector.
`timescale 1ns / 1ps
package skel_pkg;

  localparam int MaxWidth   = 1024;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int WidthW     = $clog2(MaxWidth + 1);
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 1;
  localparam int PixW       = 8;
  localparam int ColW       = 10;
  localparam int RowW       = 16;
  localparam int LineBits   = 2;
  localparam int WinBits    = 9;
  localparam int SumW       = $clog2(WinBits + 1);

  localparam logic [PixW-1:0]       PixThresh   = 8'd128;
  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 16'd480;
  localparam logic [WidthRegW-1:0]  WidthMin    = 11'd3;
  localparam logic [HeightRegW-1:0] HeightMin   = 16'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_JUNCTION = 2'd2
  } point_kind_e;

  // Position of the current pixel as seen by the window stage
  typedef struct packed {
    logic [AddrW-1:0] col;
    logic [RowW-1:0]  row;
    logic             has_result;
    logic             last;
  } pos_t;

endpackage

// File: rtl/skeleton_end_and_branch_points.sv
// Top level of the skeleton end point and junction detector.
`timescale 1ns / 1ps
// Takes one 8-bit pixel word per cycle in raster order (set when 128 or
// above) while the output is not stalled and, once the 3x3 window is full
// (row 2 and column 2 on), gives one result word per pixel: the window
// centre position and its class. A pixel is registered with its position
// and the line store read first; the window is then shifted and classified
// into the output register, and the sustained rate is one pixel per cycle
// while the output is not stalled; the registered line store read is
// bypassed when the previous pixel wrote the same column. No clearing pass
// is run after reset. Set image_width and image_height only while idle.
module skeleton_end_and_branch_points (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [skel_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [skel_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [skel_pkg::PixW-1:0]     pixel_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [skel_pkg::ColW-1:0]     center_col_o,
  output logic [skel_pkg::RowW-1:0]     center_row_o,
  output logic [1:0]                    point_kind_o,
  output logic                          last_window_o
);

  skel_pkg::pos_t                pos;
  logic                          in_acc;
  logic                          pix_bit;

  logic                          s1_v_q;
  skel_pkg::pos_t                s1_pos_q;
  logic                          s1_p_q;
  logic                          s1_fwd_q;
  logic [skel_pkg::LineBits-1:0] s1_fwd_data_q;
  logic                          s1_adv;

  logic [skel_pkg::LineBits-1:0] ram_rd;
  logic [skel_pkg::LineBits-1:0] rd_eff;
  logic [skel_pkg::LineBits-1:0] ram_wd;

  logic [skel_pkg::WinBits-1:0]  win_q, win_d;
  skel_pkg::point_kind_e         kind;

  logic                          out_v_q;
  logic [skel_pkg::ColW-1:0]     out_col_q;
  logic [skel_pkg::RowW-1:0]     out_row_q;
  skel_pkg::point_kind_e         out_kind_q;
  logic                          out_last_q;

  assign pix_bit    = (pixel_i >= skel_pkg::PixThresh);
  assign s1_adv     = s1_v_q && (!s1_pos_q.has_result || !out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  skel_pos u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .advance_i     (in_acc),
    .frame_start_i (frame_start_i),
    .pos_o         (pos)
  );

  // bit 1: two rows up, bit 0: previous row
  assign rd_eff = s1_fwd_q ? s1_fwd_data_q : ram_rd;
  assign ram_wd = {rd_eff[0], s1_p_q};

  skel_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (pos.col),
    .rd_data_o (ram_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_pos_q.col),
    .wr_data_i (ram_wd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_fwd_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q   <= 1'b1;
      s1_fwd_q <= s1_adv && (s1_pos_q.col == pos.col);
    end else if (s1_adv) begin
      s1_v_q   <= 1'b0;
      s1_fwd_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q      <= pos;
      s1_p_q        <= pix_bit;
      s1_fwd_data_q <= ram_wd;
    end
  end

  // shift left one column, new column enters at the right
  assign win_d = {s1_p_q, win_q[8], win_q[7], rd_eff[0], win_q[5], win_q[4],
                  rd_eff[1], win_q[2], win_q[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  skel_classify u_classify (
    .win_i  (win_d),
    .kind_o (kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv && s1_pos_q.has_result) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pos_q.has_result) begin
      out_col_q  <= skel_pkg::ColW'(s1_pos_q.col - 1'b1);
      out_row_q  <= s1_pos_q.row - 1'b1;
      out_kind_q <= kind;
      out_last_q <= s1_pos_q.last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign center_col_o  = out_col_q;
  assign center_row_o  = out_row_q;
  assign point_kind_o  = out_kind_q;
  assign last_window_o = out_last_q;

`ifndef ASSERT_OFF
  a_centre_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_col_o != '0) && (center_row_o != '0))
    else $error("window centre on the image border");
`endif
`ifndef ASSERT_OFF
  a_fwd_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_v_q)
    else $error("bypass flagged with no word in the window stage");
`endif
`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> $stable(out_col_q) && $stable(out_row_q))
    else $error("pending result overwritten");
`endif

endmodule

// File: rtl/skel_linebuf.sv
// Two-row line store: one word of two bits per column, registered read.
`timescale 1ns / 1ps
module skel_linebuf (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [skel_pkg::AddrW-1:0]    rd_addr_i,
  output logic [skel_pkg::LineBits-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [skel_pkg::AddrW-1:0]    wr_addr_i,
  input  logic [skel_pkg::LineBits-1:0] wr_data_i
);

  logic [skel_pkg::LineBits-1:0] mem_q [skel_pkg::MaxWidth];
  logic [skel_pkg::LineBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // old data on a same-address collision; the caller bypasses
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/skel_pos.sv
// Frame size registers and raster position counters.
`timescale 1ns / 1ps
module skel_pos (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [skel_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [skel_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          advance_i,
  input  logic                          frame_start_i,
  output skel_pkg::pos_t                pos_o
);

  logic [skel_pkg::WidthRegW-1:0]  width_q;
  logic [skel_pkg::HeightRegW-1:0] height_q;
  logic [skel_pkg::WidthRegW-1:0]  col_q, col_d;
  logic [skel_pkg::RowW-1:0]       row_q, row_d;

  logic [skel_pkg::WidthRegW-1:0]  eff_w;
  logic [skel_pkg::HeightRegW-1:0] eff_h;
  logic [skel_pkg::WidthRegW-1:0]  c0, c, cn;
  logic [skel_pkg::RowW-1:0]       r0, r;
  logic [skel_pkg::RowW:0]         r1, rn;
  logic                            wrap0, wrap1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= skel_pkg::WidthReset;
      height_q <= skel_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (skel_pkg::cfg_idx_e'(cfg_idx_i))
        skel_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[skel_pkg::WidthRegW-1:0];
        skel_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[skel_pkg::HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < skel_pkg::WidthMin) begin
      eff_w = skel_pkg::WidthMin;
    end else if (width_q > skel_pkg::WidthRegW'(skel_pkg::MaxWidth)) begin
      eff_w = skel_pkg::WidthRegW'(skel_pkg::MaxWidth);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < skel_pkg::HeightMin) ? skel_pkg::HeightMin : height_q;

    // position of this pixel, allowing for a size change since the last word
    c0    = frame_start_i ? '0 : col_q;
    r0    = frame_start_i ? '0 : row_q;
    wrap0 = (c0 >= eff_w);
    c     = wrap0 ? '0 : c0;
    r1    = {1'b0, r0} + {{skel_pkg::RowW{1'b0}}, wrap0};
    r     = (r1 >= {1'b0, eff_h}) ? '0 : r1[skel_pkg::RowW-1:0];

    // position of the following pixel
    cn    = c + 1'b1;
    rn    = {1'b0, r} + 1'b1;
    wrap1 = (cn >= eff_w);
    col_d = wrap1 ? '0 : cn;
    if (wrap1) begin
      row_d = (rn >= {1'b0, eff_h}) ? '0 : rn[skel_pkg::RowW-1:0];
    end else begin
      row_d = r;
    end

    pos_o.col        = c[skel_pkg::AddrW-1:0];
    pos_o.row        = r;
    pos_o.has_result = (r >= skel_pkg::RowW'(2)) && (c >= skel_pkg::WidthRegW'(2));
    pos_o.last       = (rn == {1'b0, eff_h}) && (cn == eff_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

`ifndef ASSERT_OFF
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_o.col} < eff_w)
    else $error("column outside the row");
  a_last_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_o.last |-> pos_o.has_result)
    else $error("last window flagged without a result");
`endif

endmodule

// File: rtl/skel_classify.sv
// 3x3 window classifier: end point, junction or nothing.
`timescale 1ns / 1ps
module skel_classify (
  input  logic [skel_pkg::WinBits-1:0] win_i,
  output skel_pkg::point_kind_e        kind_o
);

  logic [skel_pkg::SumW-1:0] sum;
  logic                      corners_clear;
  logic                      hit;
  logic [skel_pkg::WinBits-1:0] v;

  assign v = win_i;

  always_comb begin
    sum = '0;
    for (int k = 0; k < skel_pkg::WinBits; k++) begin
      sum = sum + skel_pkg::SumW'(v[k]);
    end
  end

  assign corners_clear = !v[0] && !v[2] && !v[6] && !v[8];

  // pair plus a third bit, eight orientations
  assign hit = (v[3] && v[1] && (v[5] || v[7] || v[8])) ||
               (v[1] && v[5] && (v[3] || v[6] || v[7])) ||
               (v[3] && v[7] && (v[1] || v[2] || v[5])) ||
               (v[7] && v[5] && (v[0] || v[1] || v[3])) ||
               (v[6] && v[8] && (v[0] || v[1] || v[2])) ||
               (v[8] && v[2] && (v[0] || v[3] || v[6])) ||
               (v[2] && v[0] && (v[6] || v[7] || v[8])) ||
               (v[0] && v[6] && (v[2] || v[5] || v[8]));

  always_comb begin
    kind_o = skel_pkg::KIND_NONE;
    if (v[4]) begin
      if (sum == skel_pkg::SumW'(2)) begin
        kind_o = skel_pkg::KIND_END;
      end else if (sum == skel_pkg::SumW'(5) && corners_clear) begin
        kind_o = skel_pkg::KIND_JUNCTION;
      end else if (sum == skel_pkg::SumW'(4) && hit) begin
        kind_o = skel_pkg::KIND_JUNCTION;
      end
    end
  end

endmodule
